// ----- hdl/per_channel_min_max_normalizer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-channel min/max normalizer.
// Shared helpers for concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_MIN_MAX_NORMALIZER_ASSERT_SVH
`define PER_CHANNEL_MIN_MAX_NORMALIZER_ASSERT_SVH

// Implication check, disabled during reset.
`define PCN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define PCN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/pcn_pkg.sv -----
// ----------------------------------------------------------------------------
// pcn_pkg
// Types and constants shared by the normalizer controller and datapath.
// ----------------------------------------------------------------------------
package pcn_pkg;

    localparam int CHAN_SLOTS = 64;

    localparam logic [2:0] FUNC_FIT       = 3'd0;
    localparam logic [2:0] FUNC_TRANSFORM = 3'd1;
    localparam logic [2:0] FUNC_FIT_XFORM = 3'd2;
    localparam logic [2:0] FUNC_INVERSE   = 3'd3;
    localparam logic [2:0] FUNC_QUERY     = 3'd4;
    localparam logic [2:0] FUNC_RESET     = 3'd5;

    localparam logic [1:0] CFG_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_TLOW   = 2'd1;
    localparam logic [1:0] CFG_THIGH  = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic rd;
        logic fit;
        logic prep;
        logic mul;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
    } status_t;

endpackage

// ----- hdl/pcn_ram.sv -----
// ----------------------------------------------------------------------------
// pcn_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/pcn_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcn_ctrl
// Sequencer: clearing pass after reset, then read, fit, prepare, multiply, divide and report.
// ----------------------------------------------------------------------------
`include "per_channel_min_max_normalizer_assert.svh"

module pcn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pcn_pkg::status_t status,
    output pcn_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_FIT   = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_start = first_reg;
                cmd.clr_step  = !first_reg;
                if (!first_reg && status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                cmd.fit    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul       = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `PCN_ASSERT_NEXT(a_start_goes_busy, clk, rst_n, (state_reg == S_IDLE) && start, busy)
    `PCN_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, done, !done)
    `PCN_ASSERT_IMP(a_no_cmd_when_idle, clk, rst_n, !busy, !cmd.div_step && !cmd.fit)

endmodule

// ----- hdl/pcn_dp.sv -----
// ----------------------------------------------------------------------------
// pcn_dp
// Datapath: statistics memories, fit update, multiply and serial divider.
// ----------------------------------------------------------------------------
`include "per_channel_min_max_normalizer_assert.svh"

module pcn_dp #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pcn_pkg::cmd_t                  cmd,
    output pcn_pkg::status_t               status,
    input  logic [2:0]                     func,
    input  logic [5:0]                     channel,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [6:0]                     active_channels,
    input  logic signed [SAMPLE_WIDTH-1:0] target_low,
    input  logic signed [SAMPLE_WIDTH-1:0] target_high,
    output logic                           ok,
    output logic signed [SAMPLE_WIDTH-1:0] result_value,
    output logic signed [SAMPLE_WIDTH-1:0] channel_min,
    output logic signed [SAMPLE_WIDTH-1:0] channel_max,
    output logic [SAMPLE_WIDTH-1:0]        channel_range,
    output logic [31:0]                    fit_count
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int AW  = (pcn_pkg::CHAN_SLOTS > 1) ? $clog2(pcn_pkg::CHAN_SLOTS) : 1;
    localparam int DW  = SW + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = $clog2(PW + 1);
    localparam int QW  = SW + 2;
    localparam int RW  = SW + 3;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [PW-1:0] QLIM = PW'(1) << (SW + 1);
    localparam logic [1:0] MODE_ECHO   = 2'd0;
    localparam logic [1:0] MODE_FIXED  = 2'd1;
    localparam logic [1:0] MODE_SCALED = 2'd2;

    logic [2:0]           func_reg;
    logic [6:0]           chan_reg;
    logic signed [SW-1:0] samp_reg;
    logic                 ok_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic signed [SW-1:0] min_rd, max_rd, min_reg, max_reg;
    logic [31:0]          cnt_rd, cnt_reg;
    logic                 mem_we;
    logic [AW-1:0]        addr;
    logic signed [SW-1:0] min_wd, max_wd;
    logic [31:0]          cnt_wd;

    logic [DW-1:0]        ma_reg, mb_reg, md_reg;
    logic                 neg_reg, zero_reg, divz_reg;
    logic [PW-1:0]        prod_reg, rem_reg;
    logic [CW-1:0]        bit_reg;
    logic [PW-1:0]        quo_reg;
    logic [1:0]           mode_reg;
    logic signed [SW-1:0] fixed_reg, add_reg;

    logic                 is_fit, is_xf, is_inv, is_rst;
    logic signed [SW-1:0] fmin, fmax;
    logic [31:0]          fcnt;
    logic signed [DW-1:0] a_s, b_s, d_s, range_s;
    logic [PW-1:0]        rem_sh, qsat;
    logic signed [RW-1:0] sum;
    logic signed [SW-1:0] res;

    assign is_fit = (func_reg == pcn_pkg::FUNC_FIT) || (func_reg == pcn_pkg::FUNC_FIT_XFORM);
    assign is_xf  = (func_reg == pcn_pkg::FUNC_TRANSFORM)
                 || (func_reg == pcn_pkg::FUNC_FIT_XFORM);
    assign is_inv = (func_reg == pcn_pkg::FUNC_INVERSE);
    assign is_rst = (func_reg == pcn_pkg::FUNC_RESET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end
    assign status.clr_done = (clr_addr_reg == AW'(pcn_pkg::CHAN_SLOTS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            chan_reg <= {1'b0, channel};
            samp_reg <= sample;
            ok_reg   <= ({1'b0, channel} < active_channels)
                     && (32'(channel) < 32'(pcn_pkg::CHAN_SLOTS));
        end
    end

    always_comb
    begin
        fmin = min_rd;
        fmax = max_rd;
        fcnt = cnt_rd;
        if (cnt_rd == 32'd0)
        begin
            fmin = samp_reg;
            fmax = samp_reg;
        end
        else
        begin
            if (samp_reg < min_rd)
            begin
                fmin = samp_reg;
            end
            if (samp_reg > max_rd)
            begin
                fmax = samp_reg;
            end
        end
        if (cnt_rd != 32'hFFFF_FFFF)
        begin
            fcnt = cnt_rd + 32'd1;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        addr   = chan_reg[AW-1:0];
        min_wd = SMAX;
        max_wd = SMIN;
        cnt_wd = '0;
        if (cmd.clr_start || cmd.clr_step)
        begin
            mem_we = 1'b1;
            addr   = clr_addr_reg;
        end
        else if (cmd.fit && ok_reg && is_rst)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.fit && ok_reg && is_fit)
        begin
            mem_we = 1'b1;
            min_wd = fmin;
            max_wd = fmax;
            cnt_wd = fcnt;
        end
    end

    pcn_ram #(.WIDTH(SW), .DEPTH(pcn_pkg::CHAN_SLOTS)) u_min (
        .clk(clk), .we(mem_we), .addr(addr), .wdata(min_wd), .rdata(min_rd));
    pcn_ram #(.WIDTH(SW), .DEPTH(pcn_pkg::CHAN_SLOTS)) u_max (
        .clk(clk), .we(mem_we), .addr(addr), .wdata(max_wd), .rdata(max_rd));
    pcn_ram #(.WIDTH(32), .DEPTH(pcn_pkg::CHAN_SLOTS)) u_cnt (
        .clk(clk), .we(mem_we), .addr(addr), .wdata(cnt_wd), .rdata(cnt_rd));

    always_ff @(posedge clk)
    begin
        if (cmd.fit)
        begin
            if (!ok_reg || is_rst)
            begin
                min_reg <= SMAX;
                max_reg <= SMIN;
                cnt_reg <= '0;
            end
            else if (is_fit)
            begin
                min_reg <= fmin;
                max_reg <= fmax;
                cnt_reg <= fcnt;
            end
            else
            begin
                min_reg <= min_rd;
                max_reg <= max_rd;
                cnt_reg <= cnt_rd;
            end
        end
    end

    always_comb
    begin
        range_s = DW'(max_reg) - DW'(min_reg);
        if ((cnt_reg == 32'd0) || (range_s == '0))
        begin
            range_s = DW'(1);
        end
        if (is_inv)
        begin
            a_s = DW'(samp_reg) - DW'(target_low);
            b_s = range_s;
            d_s = DW'(target_high) - DW'(target_low);
        end
        else
        begin
            a_s = DW'(samp_reg) - DW'(min_reg);
            b_s = DW'(target_high) - DW'(target_low);
            d_s = range_s;
        end
    end

    // The mode selects the echoed sample, a fixed value, or the scaled quotient plus offset.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            ma_reg   <= a_s[DW-1] ? DW'(-a_s) : DW'(a_s);
            mb_reg   <= b_s[DW-1] ? DW'(-b_s) : DW'(b_s);
            md_reg   <= d_s[DW-1] ? DW'(-d_s) : DW'(d_s);
            neg_reg  <= a_s[DW-1] ^ b_s[DW-1] ^ d_s[DW-1];
            zero_reg <= (a_s == '0) || (b_s == '0);
            divz_reg <= (d_s == '0);
            add_reg  <= is_inv ? min_reg : target_low;
            fixed_reg <= samp_reg;
            mode_reg  <= MODE_ECHO;
            if (ok_reg && is_xf)
            begin
                mode_reg <= MODE_SCALED;
                if (cnt_reg == 32'd0)
                begin
                    mode_reg  <= MODE_FIXED;
                    fixed_reg <= target_low;
                end
            end
            else if (ok_reg && is_inv)
            begin
                mode_reg <= MODE_SCALED;
                if (cnt_reg == 32'd0)
                begin
                    mode_reg  <= MODE_FIXED;
                    fixed_reg <= SMAX;
                end
                else if (d_s == '0)
                begin
                    mode_reg  <= MODE_FIXED;
                    fixed_reg <= (a_s == '0) ? min_reg : (a_s[DW-1] ? SMIN : SMAX);
                end
            end
        end
    end

    assign rem_sh = {rem_reg[PW-2:0], prod_reg[PW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            bit_reg <= CW'(PW);
        end
        else if (cmd.div_step && (bit_reg != '0))
        begin
            bit_reg <= bit_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PW'(ma_reg) * PW'(mb_reg);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.div_step && (bit_reg != '0))
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            if (rem_sh >= PW'(md_reg))
            begin
                rem_reg <= rem_sh - PW'(md_reg);
                quo_reg <= {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[PW-2:0], 1'b0};
            end
        end
    end
    assign status.div_done = (bit_reg == CW'(1));

    always_comb
    begin
        qsat = (quo_reg > QLIM) ? QLIM : quo_reg;
        if (neg_reg && !zero_reg)
        begin
            sum = -RW'(qsat[QW-1:0]) + RW'(add_reg);
        end
        else
        begin
            sum = RW'(qsat[QW-1:0]) + RW'(add_reg);
        end
        if (sum > RW'(SMAX))
        begin
            res = SMAX;
        end
        else if (sum < RW'(SMIN))
        begin
            res = SMIN;
        end
        else
        begin
            res = sum[SW-1:0];
        end
        if (mode_reg != MODE_SCALED)
        begin
            res = fixed_reg;
        end
    end

    always_comb
    begin
        ok            = ok_reg;
        result_value  = res;
        fit_count     = cnt_reg;
        channel_min   = '0;
        channel_max   = SW'(1);
        channel_range = SW'(1);
        if (cnt_reg != 32'd0)
        begin
            channel_min = min_reg;
            channel_max = max_reg;
            if (max_reg != min_reg)
            begin
                channel_range = SW'(max_reg - min_reg);
            end
        end
    end

    `PCN_ASSERT_IMP(a_div_nonzero, clk, rst_n, cmd.div_step && (mode_reg == MODE_SCALED), !divz_reg)
    `PCN_ASSERT_IMP(a_bad_chan_empty, clk, rst_n, cmd.finish && !ok_reg, cnt_reg == 32'd0)
    `PCN_ASSERT_NEXT(a_mul_starts_div, clk, rst_n, cmd.mul, bit_reg == CW'(PW))

endmodule

// ----- hdl/per_channel_min_max_normalizer.sv -----
// A start runs through read, fit, prepare, multiply and bit-serial divide to the done strobe.
// The bit-serial divider dominates; a new start is taken only once the block is idle again.
// Reset clears the statistics memories one channel per cycle after a start cycle,
// with busy high; configuration writes are accepted at all times.
// The receiver cannot stall: done marks the result for one cycle.
// ----------------------------------------------------------------------------
// per_channel_min_max_normalizer
// Per-channel running min/max with linear transform and inverse mapping.
// ----------------------------------------------------------------------------
module per_channel_min_max_normalizer #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic [2:0]                     func,
    input  logic [5:0]                     channel,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
    output logic                           ok,
    output logic signed [SAMPLE_WIDTH-1:0] result_value,
    output logic signed [SAMPLE_WIDTH-1:0] channel_min,
    output logic signed [SAMPLE_WIDTH-1:0] channel_max,
    output logic [SAMPLE_WIDTH-1:0]        channel_range,
    output logic [31:0]                    fit_count
);

    logic [6:0]                     active_reg;
    logic signed [SAMPLE_WIDTH-1:0] tlow_reg, thigh_reg;
    pcn_pkg::cmd_t                  cmd;
    pcn_pkg::status_t               status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 7'd64;
            tlow_reg   <= '0;
            thigh_reg  <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcn_pkg::CFG_ACTIVE: active_reg <= cfg_data[6:0];
                pcn_pkg::CFG_TLOW:   tlow_reg   <= cfg_data;
                pcn_pkg::CFG_THIGH:  thigh_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    pcn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .status(status),
        .cmd(cmd), .busy(busy), .done(done));

    pcn_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .func(func), .channel(channel), .sample(sample),
        .active_channels(active_reg), .target_low(tlow_reg), .target_high(thigh_reg),
        .ok(ok), .result_value(result_value), .channel_min(channel_min),
        .channel_max(channel_max), .channel_range(channel_range),
        .fit_count(fit_count));

endmodule
